// ===== sv/utfe_pkg.sv =====
// Shared types, codes and code page tables for the UTF-8 / EBCDIC transcoder.
package utfe_pkg;

    localparam logic [1:0] MODE_U2E = 2'd0;
    localparam logic [1:0] MODE_E2U = 2'd1;
    localparam logic [1:0] MODE_E2A = 2'd2;

    localparam logic [1:0] WALK_IDLE = 2'd0;
    localparam logic [1:0] WALK_C2   = 2'd1;
    localparam logic [1:0] WALK_C3   = 2'd2;

    localparam logic [7:0] SUB_BYTE       = 8'h3F;
    localparam logic [7:0] ASCII_QUESTION = 8'h3F;

    typedef struct packed {
        logic [7:0] out_first;
        logic [7:0] out_second;
        logic [1:0] out_count;
        logic       out_last;
    } res_t;

    typedef struct packed {
        logic [1:0] walk_state;
        logic [1:0] skip_count;
    } walk_t;

    // ASCII 00-7F to CP037
    localparam logic [7:0] ASC_TO_CP [128] = '{
        8'h00,8'h01,8'h02,8'h03,8'h37,8'h2D,8'h2E,8'h2F,8'h16,8'h05,8'h25,8'h0B,8'h0C,8'h0D,8'h0E,8'h0F,
        8'h10,8'h11,8'h12,8'h13,8'h3C,8'h3D,8'h32,8'h26,8'h18,8'h19,8'h3F,8'h27,8'h1C,8'h1D,8'h1E,8'h1F,
        8'h40,8'h5A,8'h7F,8'h7B,8'h5B,8'h6C,8'h50,8'h7D,8'h4D,8'h5D,8'h5C,8'h4E,8'h6B,8'h60,8'h4B,8'h61,
        8'hF0,8'hF1,8'hF2,8'hF3,8'hF4,8'hF5,8'hF6,8'hF7,8'hF8,8'hF9,8'h7A,8'h5E,8'h4C,8'h7E,8'h6E,8'h6F,
        8'h7C,8'hC1,8'hC2,8'hC3,8'hC4,8'hC5,8'hC6,8'hC7,8'hC8,8'hC9,8'hD1,8'hD2,8'hD3,8'hD4,8'hD5,8'hD6,
        8'hD7,8'hD8,8'hD9,8'hE2,8'hE3,8'hE4,8'hE5,8'hE6,8'hE7,8'hE8,8'hE9,8'hBA,8'hE0,8'hBB,8'hB0,8'h6D,
        8'h79,8'h81,8'h82,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,8'h91,8'h92,8'h93,8'h94,8'h95,8'h96,
        8'h97,8'h98,8'h99,8'hA2,8'hA3,8'hA4,8'hA5,8'hA6,8'hA7,8'hA8,8'hA9,8'hC0,8'h4F,8'hD0,8'hA1,8'h07
    };

    // Second byte 80-BF after C2 (first half) or C3 (second half) to CP037
    localparam logic [7:0] PAIR_TO_CP [128] = '{
        8'h20,8'h21,8'h22,8'h23,8'h24,8'h15,8'h06,8'h17,8'h28,8'h29,8'h2A,8'h2B,8'h2C,8'h09,8'h0A,8'h1B,
        8'h30,8'h31,8'h1A,8'h33,8'h34,8'h35,8'h36,8'h08,8'h38,8'h39,8'h3A,8'h3B,8'h04,8'h14,8'h3E,8'hFF,
        8'h41,8'hAA,8'h4A,8'hB1,8'h9F,8'hB2,8'h6A,8'hB5,8'hBD,8'hB4,8'h9A,8'h8A,8'h5F,8'hCA,8'hAF,8'hBC,
        8'h90,8'h8F,8'hEA,8'hFA,8'hBE,8'hA0,8'hB6,8'hB3,8'h9D,8'hDA,8'h9B,8'h8B,8'hB7,8'hB8,8'hB9,8'hAB,
        8'h64,8'h65,8'h62,8'h66,8'h63,8'h67,8'h9E,8'h68,8'h74,8'h71,8'h72,8'h73,8'h78,8'h75,8'h76,8'h77,
        8'hAC,8'h69,8'hED,8'hEE,8'hEB,8'hEF,8'hEC,8'hBF,8'h80,8'hFD,8'hFE,8'hFB,8'hFC,8'hAD,8'hAE,8'h59,
        8'h44,8'h45,8'h42,8'h46,8'h43,8'h47,8'h9C,8'h48,8'h54,8'h51,8'h52,8'h53,8'h58,8'h55,8'h56,8'h57,
        8'h8C,8'h49,8'hCD,8'hCE,8'hCB,8'hCF,8'hCC,8'hE1,8'h70,8'hDD,8'hDE,8'hDB,8'hDC,8'h8D,8'h8E,8'hDF
    };

    // CP037 byte to Latin-1 code point
    localparam logic [7:0] CP_TO_LATIN [256] = '{
        8'h00,8'h01,8'h02,8'h03,8'h9C,8'h09,8'h86,8'h7F,8'h97,8'h8D,8'h8E,8'h0B,8'h0C,8'h0D,8'h0E,8'h0F,
        8'h10,8'h11,8'h12,8'h13,8'h9D,8'h85,8'h08,8'h87,8'h18,8'h19,8'h92,8'h8F,8'h1C,8'h1D,8'h1E,8'h1F,
        8'h80,8'h81,8'h82,8'h83,8'h84,8'h0A,8'h17,8'h1B,8'h88,8'h89,8'h8A,8'h8B,8'h8C,8'h05,8'h06,8'h07,
        8'h90,8'h91,8'h16,8'h93,8'h94,8'h95,8'h96,8'h04,8'h98,8'h99,8'h9A,8'h9B,8'h14,8'h15,8'h9E,8'h1A,
        8'h20,8'hA0,8'hE2,8'hE4,8'hE0,8'hE1,8'hE3,8'hE5,8'hE7,8'hF1,8'hA2,8'h2E,8'h3C,8'h28,8'h2B,8'h7C,
        8'h26,8'hE9,8'hEA,8'hEB,8'hE8,8'hED,8'hEE,8'hEF,8'hEC,8'hDF,8'h21,8'h24,8'h2A,8'h29,8'h3B,8'hAC,
        8'h2D,8'h2F,8'hC2,8'hC4,8'hC0,8'hC1,8'hC3,8'hC5,8'hC7,8'hD1,8'hA6,8'h2C,8'h25,8'h5F,8'h3E,8'h3F,
        8'hF8,8'hC9,8'hCA,8'hCB,8'hC8,8'hCD,8'hCE,8'hCF,8'hCC,8'h60,8'h3A,8'h23,8'h40,8'h27,8'h3D,8'h22,
        8'hD8,8'h61,8'h62,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'hAB,8'hBB,8'hF0,8'hFD,8'hFE,8'hB1,
        8'hB0,8'h6A,8'h6B,8'h6C,8'h6D,8'h6E,8'h6F,8'h70,8'h71,8'h72,8'hAA,8'hBA,8'hE6,8'hB8,8'hC6,8'hA4,
        8'hB5,8'h7E,8'h73,8'h74,8'h75,8'h76,8'h77,8'h78,8'h79,8'h7A,8'hA1,8'hBF,8'hD0,8'hDD,8'hDE,8'hAE,
        8'h5E,8'hA3,8'hA5,8'hB7,8'hA9,8'hA7,8'hB6,8'hBC,8'hBD,8'hBE,8'h5B,8'h5D,8'hAF,8'hA8,8'hB4,8'hD7,
        8'h7B,8'h41,8'h42,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'hAD,8'hF4,8'hF6,8'hF2,8'hF3,8'hF5,
        8'h7D,8'h4A,8'h4B,8'h4C,8'h4D,8'h4E,8'h4F,8'h50,8'h51,8'h52,8'hB9,8'hFB,8'hFC,8'hF9,8'hFA,8'hFF,
        8'h5C,8'hF7,8'h53,8'h54,8'h55,8'h56,8'h57,8'h58,8'h59,8'h5A,8'hB2,8'hD4,8'hD6,8'hD2,8'hD3,8'hD5,
        8'h30,8'h31,8'h32,8'h33,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,8'hB3,8'hDB,8'hDC,8'hD9,8'hDA,8'h9F
    };

endpackage

// ===== sv/utfe_if.sv =====
// Valid/ready channel interfaces for the transcoder input bytes and results.
interface utfe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface utfe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_first;
    logic [7:0] out_second;
    logic [1:0] out_count;
    logic       out_last;

    modport source (output valid, output out_first, output out_second,
                    output out_count, output out_last, input ready);
    modport sink   (input valid, input out_first, input out_second,
                    input out_count, input out_last, output ready);
endinterface

// ===== sv/utf8_ebcdic_transcoder.sv =====
// Top level of the UTF-8 / CP037 / ASCII byte transcoder.
// Datapath: a transferred byte lands in the input register; its result is written
//   to the result register when the input stage advances and offered from then on.
// Throughput: one byte per cycle while the sink takes results; each step is a table lookup plus the lead state.
// Reset: clears both valid flags, the mode register (UTF-8 to CP037) and the
//   pending-lead / skip state. Payload registers are not reset.
module utf8_ebcdic_transcoder
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_wr_data,
    utfe_in_if.sink    in_ch,
    utfe_out_if.source out_ch
);
    import utfe_pkg::*;

    // Configuration: one mode register; the user must write it only while the block is idle (not enforced here).
    logic [1:0] mode_reg;

    // Input register stage.
    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;

    // Result register stage.
    logic       out_valid_reg;
    res_t       res_reg;
    res_t       res;

    // The input stage moves forward when the result register is empty or is
    // being drained this cycle. The walk state steps in the same cycle, so
    // state and results stay in byte order.
    logic       advance;
    logic       in_xfer;

    assign advance     = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || advance;
    assign in_xfer     = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_U2E;
        end
        else if (cfg_wr_en)
        begin
            mode_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            byte_reg <= in_ch.in_byte;
            last_reg <= in_ch.in_last;
        end
    end

    // Translation and lead tracking for the byte held in the input register.
    utfe_step u_step
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .mode    (mode_reg),
        .in_byte (byte_reg),
        .in_last (last_reg),
        .res     (res)
    );

    // Result register: loaded on advance, emptied when the sink takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.out_first  = res_reg.out_first;
    assign out_ch.out_second = res_reg.out_second;
    assign out_ch.out_count  = res_reg.out_count;
    assign out_ch.out_last   = res_reg.out_last;

endmodule

// ===== sv/utfe_step.sv =====
// Per-byte translation logic with the pending-lead and skip state.
module utfe_step
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step_en,
    input  logic [1:0]    mode,
    input  logic [7:0]    in_byte,
    input  logic          in_last,
    output utfe_pkg::res_t res
);
    import utfe_pkg::*;

    walk_t      st_reg;
    walk_t      st_next;
    logic [7:0] latin;
    logic [7:0] first;
    logic [7:0] second;
    logic [1:0] count;

    assign latin = CP_TO_LATIN[in_byte];

    always_comb
    begin
        first   = 8'h00;
        second  = 8'h00;
        count   = 2'd0;
        st_next = st_reg;
        case (mode)
            MODE_U2E:
            begin
                if (st_reg.skip_count != 2'd0)
                begin
                    st_next.skip_count = st_reg.skip_count - 2'd1;
                end
                else if (st_reg.walk_state != WALK_IDLE)
                begin
                    if (in_byte[7:6] == 2'b10)
                        first = PAIR_TO_CP[{st_reg.walk_state == WALK_C3, in_byte[5:0]}];
                    else
                        first = SUB_BYTE;
                    count              = 2'd1;
                    st_next.walk_state = WALK_IDLE;
                end
                else if (!in_byte[7])
                begin
                    first = ASC_TO_CP[in_byte[6:0]];
                    count = 2'd1;
                end
                else if (in_byte == 8'hC2 || in_byte == 8'hC3)
                begin
                    st_next.walk_state = in_byte[0] ? WALK_C3 : WALK_C2;
                    if (in_last)
                    begin
                        first = SUB_BYTE;
                        count = 2'd1;
                    end
                end
                else
                begin
                    first = SUB_BYTE;
                    count = 2'd1;
                    // drop the rest of a multi-byte sequence
                    if (in_byte >= 8'hC4 && in_byte <= 8'hDF)
                        st_next.skip_count = 2'd1;
                    else if (in_byte >= 8'hE0 && in_byte <= 8'hEF)
                        st_next.skip_count = 2'd2;
                    else if (in_byte >= 8'hF0 && in_byte <= 8'hF4)
                        st_next.skip_count = 2'd3;
                end
            end
            MODE_E2U:
            begin
                if (!latin[7])
                begin
                    first = latin;
                    count = 2'd1;
                end
                else
                begin
                    first  = {6'b110000, latin[7:6]};
                    second = {2'b10, latin[5:0]};
                    count  = 2'd2;
                end
            end
            MODE_E2A:
            begin
                first = latin[7] ? ASCII_QUESTION : latin;
                count = 2'd1;
            end
            default:
            begin
                first = 8'h00;
            end
        endcase
        if (in_last)
        begin
            st_next.walk_state = WALK_IDLE;
            st_next.skip_count = 2'd0;
        end
    end

    assign res.out_first  = first;
    assign res.out_second = second;
    assign res.out_count  = count;
    assign res.out_last   = in_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '{walk_state: WALK_IDLE, skip_count: 2'd0};
        end
        else if (step_en)
        begin
            st_reg <= st_next;
        end
    end

endmodule
